/* rtl/core/ymsnd_pkg.sv */
package ymsnd_pkg;

    localparam int LONG_BLOCK  = 1024;
    localparam int SHORT_BLOCK = 128;
    localparam int ADDR_W      = $clog2(LONG_BLOCK);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] PAD    = 8'h1A;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0] ATTEMPT_RST = 4'd10;
    localparam logic [6:0] START_RST   = 7'd100;
    localparam logic [1:0] DSTART_RST  = 2'd3;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_PAYLOAD = 3'd1,
        REQ_RX      = 3'd2,
        REQ_TIMEOUT = 3'd3,
        REQ_SLOT    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        CFG_FILE_LEN  = 2'd0,
        CFG_ATTEMPT   = 2'd1,
        CFG_START_LIM = 2'd2,
        CFG_DSTART    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_TX     = 2'd0,
        K_REQ    = 2'd1,
        K_FINISH = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_START = 3'd1,
        ST_HDR_FAIL = 3'd2,
        ST_CANCEL   = 3'd3,
        ST_NO_DATA  = 3'd4,
        ST_DATA_FAIL= 3'd5,
        ST_EOT_FAIL = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAIT_START, PH_HDR_FILL, PH_HDR_SEND, PH_HDR_WAIT,
        PH_WAIT_DATA_C, PH_DATA_FILL, PH_DATA_SEND, PH_DATA_WAIT,
        PH_EOT_SEND, PH_EOT_WAIT_ACK, PH_EOT_WAIT_C, PH_CLOSE_SEND, PH_CLOSE_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        SRC_LIT, SRC_MEM, SRC_CRCH, SRC_CRCL
    } t_src;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        t_src        src;
        logic [7:0]  lit;
        logic        fend;
        logic [10:0] rlen;
        t_status     status;
        logic        crc_clr;
        logic        crc_upd;
    } t_stage;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/ymsnd_store.sv */
module ymsnd_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ymsnd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [ymsnd_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);
    import ymsnd_pkg::*;

    logic [7:0] r_mem [LONG_BLOCK];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* rtl/core/ymsnd_ctrl.sv */
module ymsnd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [23:0]                  i_cfg_wdata,
    input  logic                         i_acc,
    input  logic [2:0]                   i_req,
    input  logic [7:0]                   i_rbyte,
    output logic                         o_we,
    output logic [ymsnd_pkg::ADDR_W-1:0] o_waddr,
    output logic [ymsnd_pkg::ADDR_W-1:0] o_raddr,
    output ymsnd_pkg::t_stage            o_stage
);
    import ymsnd_pkg::*;

    logic [23:0] r_flen;
    logic [3:0]  r_alim;
    logic [6:0]  r_slim;
    logic [1:0]  r_dst;
    t_phase      r_ph, n_ph;
    logic [10:0] r_idx, n_idx;
    logic [7:0]  r_bn, n_bn;
    logic [23:0] r_bl, n_bl;
    logic [10:0] r_fill, n_fill;
    logic [6:0]  r_try, n_try;

    logic        resp, is_c, is_ack, is_can;
    logic [3:0]  alim;
    logic [1:0]  dlim;
    logic [6:0]  try_inc;
    logic [10:0] len, didx, target, fill_inc;
    logic [23:0] nb;
    logic [7:0]  seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen <= '0;
            r_alim <= ATTEMPT_RST;
            r_slim <= START_RST;
            r_dst  <= DSTART_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILE_LEN:  r_flen <= i_cfg_wdata;
                CFG_ATTEMPT:   r_alim <= i_cfg_wdata[3:0];
                CFG_START_LIM: r_slim <= i_cfg_wdata[6:0];
                CFG_DSTART:    r_dst  <= i_cfg_wdata[1:0];
                default:       r_flen <= r_flen;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_idx  <= '0;
            r_bn   <= 8'd1;
            r_bl   <= '0;
            r_fill <= '0;
            r_try  <= '0;
        end else begin
            r_ph   <= n_ph;
            r_idx  <= n_idx;
            r_bn   <= n_bn;
            r_bl   <= n_bl;
            r_fill <= n_fill;
            r_try  <= n_try;
        end
    end

    always_comb begin
        n_ph   = r_ph;
        n_idx  = r_idx;
        n_bn   = r_bn;
        n_bl   = r_bl;
        n_fill = r_fill;
        n_try  = r_try;
        o_stage = '0;
        o_stage.kind   = K_TX;
        o_stage.src    = SRC_LIT;
        o_stage.status = ST_OK;
        o_we    = 1'b0;
        o_waddr = r_fill[ADDR_W-1:0];

        is_c   = (i_rbyte == CH_C)   && (i_req == REQ_RX);
        is_ack = (i_rbyte == CH_ACK) && (i_req == REQ_RX);
        is_can = (i_rbyte == CH_CAN) && (i_req == REQ_RX);
        resp   = (i_req == REQ_TIMEOUT) ||
                 ((i_req == REQ_RX) && (is_c || is_ack || is_can ||
                  i_rbyte == CH_NAK || i_rbyte == CH_EOT));
        alim    = (r_alim == 4'd0) ? 4'd1 : r_alim;
        dlim    = (r_dst == 2'd0) ? 2'd1 : r_dst;
        try_inc = r_try + 7'd1;
        fill_inc = r_fill + 11'd1;
        nb = r_bl;

        len  = (r_ph == PH_DATA_SEND && r_fill >= 11'(SHORT_BLOCK)) ?
               11'(LONG_BLOCK) : 11'(SHORT_BLOCK);
        seq  = (r_ph == PH_DATA_SEND) ? r_bn : 8'd0;
        didx = r_idx - 11'd3;
        o_raddr = didx[ADDR_W-1:0];
        target = (r_ph == PH_HDR_FILL) ? 11'(SHORT_BLOCK) :
                 ((r_bl > 24'(LONG_BLOCK)) ? 11'(LONG_BLOCK) : r_bl[10:0]);

        if (i_acc) begin
            case (i_req)
                REQ_START: begin
                    n_ph = PH_WAIT_START;
                    n_try = '0; n_bn = 8'd1; n_idx = '0; n_bl = '0; n_fill = '0;
                end
                REQ_PAYLOAD: begin
                    if (r_ph == PH_HDR_FILL || r_ph == PH_DATA_FILL) begin
                        o_we = 1'b1;
                        n_fill = fill_inc;
                        if (fill_inc >= target) begin
                            n_ph  = (r_ph == PH_HDR_FILL) ? PH_HDR_SEND : PH_DATA_SEND;
                            n_idx = '0;
                            n_try = '0;
                        end
                    end
                end
                REQ_SLOT: begin
                    if (r_ph == PH_HDR_SEND || r_ph == PH_DATA_SEND ||
                        r_ph == PH_CLOSE_SEND) begin
                        o_stage.valid = 1'b1;
                        n_idx = r_idx + 11'd1;
                        if (r_idx == 11'd0) begin
                            o_stage.lit = (len == 11'(SHORT_BLOCK)) ? CH_SOH : CH_STX;
                            o_stage.crc_clr = 1'b1;
                        end else if (r_idx == 11'd1) begin
                            o_stage.lit = seq;
                        end else if (r_idx == 11'd2) begin
                            o_stage.lit = ~seq;
                        end else if (r_idx < len + 11'd3) begin
                            o_stage.crc_upd = 1'b1;
                            if (r_ph == PH_CLOSE_SEND) begin
                                o_stage.lit = 8'd0;
                            end else if (didx < r_fill) begin
                                o_stage.src = SRC_MEM;
                            end else begin
                                o_stage.lit = PAD;
                            end
                        end else if (r_idx == len + 11'd3) begin
                            o_stage.src = SRC_CRCH;
                        end else begin
                            o_stage.src  = SRC_CRCL;
                            o_stage.fend = 1'b1;
                            n_idx = '0;
                            n_ph  = (r_ph == PH_DATA_SEND) ? PH_DATA_WAIT :
                                    (r_ph == PH_HDR_SEND) ? PH_HDR_WAIT : PH_CLOSE_WAIT;
                        end
                    end else if (r_ph == PH_EOT_SEND) begin
                        o_stage.valid = 1'b1;
                        o_stage.lit   = CH_EOT;
                        o_stage.fend  = 1'b1;
                        n_ph = PH_EOT_WAIT_ACK;
                    end
                end
                REQ_RX, REQ_TIMEOUT: begin
                    if (resp) begin
                        case (r_ph)
                            PH_WAIT_START: begin
                                if (is_c) begin
                                    n_ph = PH_HDR_FILL;
                                    n_fill = '0;
                                    o_stage.valid = 1'b1;
                                    o_stage.kind  = K_REQ;
                                    o_stage.rlen  = 11'(SHORT_BLOCK);
                                end else if (r_try > r_slim || r_try == 7'd127) begin
                                    n_ph = PH_IDLE;
                                    o_stage.valid = 1'b1;
                                    o_stage.kind = K_FINISH;
                                    o_stage.status = ST_NO_START;
                                end else begin
                                    n_try = try_inc;
                                end
                            end
                            PH_HDR_WAIT, PH_DATA_WAIT, PH_EOT_WAIT_ACK, PH_EOT_WAIT_C: begin
                                if (is_ack && r_ph == PH_HDR_WAIT) begin
                                    n_ph = PH_WAIT_DATA_C;
                                    n_try = '0;
                                end else if (is_ack && r_ph == PH_EOT_WAIT_ACK) begin
                                    n_ph = PH_EOT_WAIT_C;
                                end else if (is_c && r_ph == PH_EOT_WAIT_C) begin
                                    n_ph = PH_CLOSE_SEND;
                                    n_idx = '0;
                                end else if (is_ack && r_ph == PH_DATA_WAIT) begin
                                    n_bn = r_bn + 8'd1;
                                    nb = r_bl - 24'(r_fill);
                                    n_bl = nb;
                                    n_try = '0;
                                    if (nb == 24'd0) begin
                                        n_ph = PH_EOT_SEND;
                                    end else begin
                                        n_ph = PH_DATA_FILL;
                                        n_fill = '0;
                                        o_stage.valid = 1'b1;
                                        o_stage.kind = K_REQ;
                                        o_stage.rlen = (nb > 24'(LONG_BLOCK)) ?
                                                       11'(LONG_BLOCK) : nb[10:0];
                                    end
                                end else if (is_can && (r_ph == PH_HDR_WAIT ||
                                                        r_ph == PH_DATA_WAIT)) begin
                                    n_ph = PH_IDLE;
                                    o_stage.valid = 1'b1;
                                    o_stage.kind = K_FINISH;
                                    o_stage.status = ST_CANCEL;
                                end else begin
                                    n_try = try_inc;
                                    if (try_inc >= 7'(alim)) begin
                                        n_ph = PH_IDLE;
                                        o_stage.valid = 1'b1;
                                        o_stage.kind = K_FINISH;
                                        o_stage.status = (r_ph == PH_HDR_WAIT) ? ST_HDR_FAIL :
                                                         (r_ph == PH_DATA_WAIT) ? ST_DATA_FAIL :
                                                         ST_EOT_FAIL;
                                    end else if (r_ph == PH_HDR_WAIT) begin
                                        n_ph = PH_HDR_SEND; n_idx = '0;
                                    end else if (r_ph == PH_DATA_WAIT) begin
                                        n_ph = PH_DATA_SEND; n_idx = '0;
                                    end else begin
                                        n_ph = PH_EOT_SEND;
                                    end
                                end
                            end
                            PH_WAIT_DATA_C: begin
                                if (is_c) begin
                                    nb = r_flen;
                                    n_bl = nb;
                                    n_try = '0;
                                    if (nb == 24'd0) begin
                                        n_ph = PH_EOT_SEND;
                                    end else begin
                                        n_ph = PH_DATA_FILL;
                                        n_fill = '0;
                                        o_stage.valid = 1'b1;
                                        o_stage.kind = K_REQ;
                                        o_stage.rlen = (nb > 24'(LONG_BLOCK)) ?
                                                       11'(LONG_BLOCK) : nb[10:0];
                                    end
                                end else begin
                                    n_try = try_inc;
                                    if (try_inc >= 7'(dlim)) begin
                                        n_ph = PH_IDLE;
                                        o_stage.valid = 1'b1;
                                        o_stage.kind = K_FINISH;
                                        o_stage.status = ST_NO_DATA;
                                    end
                                end
                            end
                            PH_CLOSE_WAIT: begin
                                n_ph = PH_IDLE;
                                o_stage.valid = 1'b1;
                                o_stage.kind = K_FINISH;
                                o_stage.status = ST_OK;
                            end
                            default: n_ph = r_ph;
                        endcase
                    end
                end
                default: n_ph = r_ph;
            endcase
        end
    end
endmodule

/* rtl/core/ymsnd_emit.sv */
module ymsnd_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ymsnd_pkg::t_stage i_stage,
    input  logic [7:0]        i_rdata,
    input  logic              i_out_ready,
    output logic              o_stall,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_tx,
    output logic              o_fend,
    output logic [10:0]       o_rlen,
    output logic [2:0]        o_status
);
    import ymsnd_pkg::*;

    t_stage      r_s2;
    logic [15:0] r_crc;
    logic [15:0] crc_base;
    logic [7:0]  byte_val;
    logic        load;

    assign o_stall  = r_s2.valid && o_valid && !i_out_ready;
    assign load     = r_s2.valid && !o_stall;
    assign crc_base = r_s2.crc_clr ? 16'd0 : r_crc;

    always_comb begin
        case (r_s2.src)
            SRC_MEM:  byte_val = i_rdata;
            SRC_CRCH: byte_val = r_crc[15:8];
            SRC_CRCL: byte_val = r_crc[7:0];
            default:  byte_val = r_s2.lit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            o_valid    <= 1'b0;
            r_crc      <= '0;
        end else begin
            if (!o_stall) begin
                r_s2 <= i_stage;
            end
            if (load) begin
                o_valid <= 1'b1;
                if (r_s2.crc_upd) begin
                    r_crc <= crc_byte(crc_base, byte_val);
                end else begin
                    r_crc <= crc_base;
                end
            end else if (i_out_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_kind   <= r_s2.kind;
            o_tx     <= (r_s2.kind == K_TX) ? byte_val : 8'd0;
            o_fend   <= r_s2.fend;
            o_rlen   <= r_s2.rlen;
            o_status <= r_s2.status;
        end
    end
endmodule

/* rtl/core/ymodem_1k_sender_unit.sv */
// A result item passes the second-stage register, then the output register. Throughput:
// one item per cycle unless the output stalls, set by the one block buffer read in the
// first stage and the CRC update in the second stage.
// Reset: synchronous, active low; clears phase, counters and valid flags and restores
// the register defaults. The block buffer is not cleared and needs no clearing pass.
module ymodem_1k_sender_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // payload_byte[7:0], rx_byte[15:8]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // tx_byte[7:0], request_length[18:8], status[21:19]
    output logic [1:0]  m_axis_tuser,  // out_kind[1:0]
    output logic        m_axis_tlast   // frame_end
);
    import ymsnd_pkg::*;

    logic              acc, stall, we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        rdata;
    t_stage            stage;
    logic [7:0]        tx;
    logic [10:0]       rlen;
    logic [2:0]        status;

    // Hold new items only while a result waits in both the second stage and the output.
    assign s_axis_tready = !stall;
    assign acc = s_axis_tvalid && s_axis_tready;

    ymsnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_acc      (acc),
        .i_req      (s_axis_tuser),
        .i_rbyte    (s_axis_tdata[15:8]),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_raddr    (raddr),
        .o_stage    (stage)
    );

    // Block buffer: payload bytes go in during fill, frame bytes come out during send.
    ymsnd_store u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(s_axis_tdata[7:0]),
        .i_re   (!stall),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Second stage: pick the byte, advance the CRC, drive the output register.
    ymsnd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_rdata    (rdata),
        .i_out_ready(m_axis_tready),
        .o_stall    (stall),
        .o_valid    (m_axis_tvalid),
        .o_kind     (m_axis_tuser),
        .o_tx       (tx),
        .o_fend     (m_axis_tlast),
        .o_rlen     (rlen),
        .o_status   (status)
    );

    assign m_axis_tdata = {2'b00, status, rlen, tx};
endmodule

/* rtl/core/ymsnd_checker.sv */
module ymsnd_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import ymsnd_pkg::*;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= K_FINISH) else $error("bad kind");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser == K_TX) else $error("bad last");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != K_REQ) |-> m_axis_tdata[18:8] == 11'd0)
        else $error("stray length");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output dropped");
endmodule

bind ymodem_1k_sender_unit ymsnd_sva u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

/* tb/sv/ymsnd_checker.sv */
module ymsnd_checker
    import ymsnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,
    input  logic [2:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic [1:0]  i_out_user,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EV_TIMEOUT = 256;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        logic        fend;
        logic [10:0] rlen;
        t_status     st;
    } t_line_item;

    t_line_item  line_q[$];

    // sender state
    t_phase      ph;
    logic [7:0]  blk_mem [LONG_BLOCK];
    int          sidx;
    logic [15:0] crc;
    logic [7:0]  blk_no;
    logic [23:0] left;
    logic [10:0] fill;
    logic [6:0]  tries;

    // registers
    logic [23:0] r_flen;
    logic [3:0]  r_attempt;
    logic [6:0]  r_start_lim;
    logic [1:0]  r_dstart;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [10:0] block_len();
        return (left > LONG_BLOCK) ? 11'(LONG_BLOCK) : left[10:0];
    endfunction

    task automatic push(input t_kind k, input logic [7:0] tx, input logic fe,
                        input logic [10:0] rl, input t_status st);
        t_line_item e;
        e.kind = k; e.tx = tx; e.fend = fe; e.rlen = rl; e.st = st;
        line_q.push_back(e);
    endtask

    task automatic end_transfer(input t_status st);
        ph = PH_IDLE;
        push(K_FINISH, 8'h00, 1'b0, 11'd0, st);
    endtask

    task automatic restart_frame(input t_phase p);
        ph   = p;
        sidx = 0;
        crc  = 16'h0000;
    endtask

    task automatic ask_block();
        tries = 7'd0;
        if (left == 0) begin
            ph = PH_EOT_SEND;
        end else begin
            ph   = PH_DATA_FILL;
            fill = 11'd0;
            push(K_REQ, 8'h00, 1'b0, block_len(), ST_OK);
        end
    endtask

    task automatic count_failure(input t_phase resend, input t_status st);
        logic [6:0] lim;
        lim   = (r_attempt == 0) ? 7'd1 : 7'(r_attempt);
        tries = tries + 7'd1;
        if (tries >= lim) end_transfer(st);
        else if (resend == PH_EOT_SEND) ph = PH_EOT_SEND;
        else restart_frame(resend);
    endtask

    task automatic frame_byte();
        int         flen;
        logic [7:0] first, seq, b;
        logic       last;
        t_phase     next_ph;
        last = 1'b0;
        if (ph == PH_DATA_SEND) begin
            flen    = (fill < SHORT_BLOCK) ? SHORT_BLOCK : LONG_BLOCK;
            first   = (fill < SHORT_BLOCK) ? CH_SOH : CH_STX;
            seq     = blk_no;
            next_ph = PH_DATA_WAIT;
        end else begin
            flen    = SHORT_BLOCK;
            first   = CH_SOH;
            seq     = 8'h00;
            next_ph = (ph == PH_HDR_SEND) ? PH_HDR_WAIT : PH_CLOSE_WAIT;
        end
        if (sidx == 0) b = first;
        else if (sidx == 1) b = seq;
        else if (sidx == 2) b = ~seq;
        else if (sidx < flen + 3) begin
            if (ph == PH_CLOSE_SEND) b = 8'h00;
            else if (sidx - 3 < fill) b = blk_mem[sidx - 3];
            else b = PAD;
            crc = crc_next(crc, b);
        end else if (sidx == flen + 3) b = crc[15:8];
        else begin
            b    = crc[7:0];
            last = 1'b1;
        end
        sidx = sidx + 1;
        if (last) begin
            ph   = next_ph;
            sidx = 0;
        end
        push(K_TX, b, last, 11'd0, ST_OK);
    endtask

    task automatic on_reply(input int ev);
        case (ph)
            PH_WAIT_START: begin
                if (ev == CH_C) begin
                    ph   = PH_HDR_FILL;
                    fill = 11'd0;
                    push(K_REQ, 8'h00, 1'b0, 11'(SHORT_BLOCK), ST_OK);
                end else if (tries > r_start_lim || tries >= 7'd127) end_transfer(ST_NO_START);
                else tries = tries + 7'd1;
            end
            PH_HDR_WAIT: begin
                if (ev == CH_ACK) begin
                    ph    = PH_WAIT_DATA_C;
                    tries = 7'd0;
                end else if (ev == CH_CAN) end_transfer(ST_CANCEL);
                else count_failure(PH_HDR_SEND, ST_HDR_FAIL);
            end
            PH_WAIT_DATA_C: begin
                if (ev == CH_C) begin
                    left = r_flen;
                    ask_block();
                end else begin
                    tries = tries + 7'd1;
                    if (tries >= ((r_dstart == 0) ? 7'd1 : 7'(r_dstart)))
                        end_transfer(ST_NO_DATA);
                end
            end
            PH_DATA_WAIT: begin
                if (ev == CH_ACK) begin
                    blk_no = blk_no + 8'd1;
                    left   = left - 24'(fill);
                    ask_block();
                end else if (ev == CH_CAN) end_transfer(ST_CANCEL);
                else count_failure(PH_DATA_SEND, ST_DATA_FAIL);
            end
            PH_EOT_WAIT_ACK: begin
                if (ev == CH_ACK) ph = PH_EOT_WAIT_C;
                else count_failure(PH_EOT_SEND, ST_EOT_FAIL);
            end
            PH_EOT_WAIT_C: begin
                if (ev == CH_C) restart_frame(PH_CLOSE_SEND);
                else count_failure(PH_EOT_SEND, ST_EOT_FAIL);
            end
            PH_CLOSE_WAIT: end_transfer(ST_OK);
            default: ;
        endcase
    endtask

    task automatic predict(input logic [2:0] req, input logic [7:0] pb, input logic [7:0] rb);
        logic [10:0] tgt;
        case (req)
            REQ_START: begin
                ph = PH_WAIT_START;
                tries = 7'd0; blk_no = 8'd1; sidx = 0; crc = 16'h0000;
                left = 24'd0; fill = 11'd0;
            end
            REQ_PAYLOAD: begin
                if (ph == PH_HDR_FILL || ph == PH_DATA_FILL) begin
                    tgt = (ph == PH_HDR_FILL) ? 11'(SHORT_BLOCK) : block_len();
                    blk_mem[fill[ADDR_W-1:0]] = pb;
                    fill = fill + 11'd1;
                    if (fill >= tgt) begin
                        restart_frame((ph == PH_HDR_FILL) ? PH_HDR_SEND : PH_DATA_SEND);
                        tries = 7'd0;
                    end
                end
            end
            REQ_RX: begin
                if (rb == CH_ACK || rb == CH_NAK || rb == CH_CAN || rb == CH_C || rb == CH_EOT)
                    on_reply(int'(rb));
            end
            REQ_TIMEOUT: on_reply(EV_TIMEOUT);
            REQ_SLOT: begin
                if (ph == PH_HDR_SEND || ph == PH_DATA_SEND || ph == PH_CLOSE_SEND) begin
                    frame_byte();
                end else if (ph == PH_EOT_SEND) begin
                    ph = PH_EOT_WAIT_ACK;
                    push(K_TX, CH_EOT, 1'b1, 11'd0, ST_OK);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_results    = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_line_item e;
        if (!i_rst_n) begin
            ph = PH_IDLE; sidx = 0; crc = 16'h0000; blk_no = 8'd1;
            left = 24'd0; fill = 11'd0; tries = 7'd0;
            r_flen = 24'd0; r_attempt = ATTEMPT_RST; r_start_lim = START_RST;
            r_dstart = DSTART_RST;
            line_q.delete();
        end else begin
            // results come from earlier items, so compare before predicting
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (line_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tuser %0d tdata 0x%06h",
                             $time, i_out_user, i_out_data);
                    o_fail_count++;
                end else begin
                    e = line_q.pop_front();
                    check_field("out_kind", e.kind, i_out_user);
                    check_field("tx_byte", e.tx, i_out_data[7:0]);
                    check_field("frame_end", e.fend, i_out_last);
                    check_field("request_length", e.rlen, i_out_data[18:8]);
                    check_field("status", e.st, i_out_data[21:19]);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FILE_LEN:  r_flen      = i_cfg_wdata;
                    CFG_ATTEMPT:   r_attempt   = i_cfg_wdata[3:0];
                    CFG_START_LIM: r_start_lim = i_cfg_wdata[6:0];
                    CFG_DSTART:    r_dstart    = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict(i_in_user, i_in_data[7:0], i_in_data[15:8]);
        end
        o_pending = line_q.size();
    end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    import ymsnd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_GOAL   = 1150;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // payload_byte[7:0], rx_byte[15:8]
    logic [2:0]  s_axis_tuser;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // tx_byte[7:0], request_length[18:8], status[21:19]
    logic [1:0]  m_axis_tuser;   // out_kind[1:0]
    logic        m_axis_tlast;   // frame_end

    int  fail_count, pending, results;
    int  items_sent, sessions, cycles;
    bit  calm, hold_req;

    // stimulus-side copies of the limits, used to know when a transfer gives up
    int  lim_attempt, lim_start;

    ymodem_1k_sender_unit u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
    );

    ymsnd_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser), .i_out_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Watchdog: give up on a hung run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results still awaited", cycles, pending);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Offer one item; entered and left at a falling edge, tvalid left high.
    task automatic send(input t_req req, input logic [7:0] pb, input logic [7:0] rb);
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {rb, pb};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        calm = (items_sent >= 300 && items_sent < 700);
    endtask

    task automatic send_rx(input logic [7:0] rb);
        send(REQ_RX, $urandom_range(0, 255), rb);
    endtask

    task automatic send_slots(input int n);
        repeat (n) send(REQ_SLOT, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic send_payload(input int n);
        repeat (n) send(REQ_PAYLOAD, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // Drop tvalid and wait until every result has come, plus the pipeline depth.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_ATTEMPT:   lim_attempt = (val[3:0] == 0) ? 1 : val[3:0];
            CFG_START_LIM: lim_start   = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [23:0] flen, input int att, input int slim, input int dst);
        settle();
        cfg_write(CFG_FILE_LEN, flen);
        cfg_write(CFG_ATTEMPT, att);
        cfg_write(CFG_START_LIM, slim);
        cfg_write(CFG_DSTART, dst);
    endtask

    // Something the block must ignore in a wait phase.
    task automatic send_junk();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: begin
                do b = $urandom_range(0, 255);
                while (b == CH_ACK || b == CH_NAK || b == CH_CAN || b == CH_C || b == CH_EOT);
                send_rx(b);
            end
            1: send(REQ_PAYLOAD, $urandom_range(0, 255), $urandom_range(0, 255));
            2: send(REQ_SLOT, $urandom_range(0, 255), $urandom_range(0, 255));
            default: send(t_req'($urandom_range(5, 7)), $urandom_range(0, 255),
                          $urandom_range(0, 255));
        endcase
    endtask

    // Answer a frame or EOT: 0 taken, 1 one more failed try, 2 transfer cancelled.
    task automatic answer(input bit can_ok, output int verdict);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            send_junk();
            r = $urandom_range(10, 99);
        end
        if (r < 72) begin
            send_rx(CH_ACK); verdict = 0;
        end else if (r < 84) begin
            send_rx(CH_NAK); verdict = 1;
        end else if (r < 92) begin
            send(REQ_TIMEOUT, $urandom_range(0, 255), $urandom_range(0, 255)); verdict = 1;
        end else if (r < 96 || !can_ok) begin
            send_rx(CH_EOT); verdict = 1;
        end else begin
            send_rx(CH_CAN); verdict = 2;
        end
    endtask

    // Send a frame of n slots until it is taken; 0 when the transfer has ended.
    task automatic frame_until_taken(input int n, output bit alive);
        int tries, v;
        tries = 0;
        alive = 1'b0;
        forever begin
            send_slots(n);
            if ($urandom_range(0, 9) == 0) send_junk();
            answer(1'b1, v);
            if (v == 2) return;
            if (v == 0) break;
            tries++;
            if (tries >= lim_attempt) return;
        end
        alive = 1'b1;
    endtask

    task automatic open_and_header(output bit alive);
        int waits;
        send(REQ_START, $urandom_range(0, 255), $urandom_range(0, 255));
        waits = $urandom_range(0, 2);
        if (waits > lim_start) waits = 0;
        repeat (waits) send(REQ_TIMEOUT, $urandom_range(0, 255), $urandom_range(0, 255));
        send_rx(CH_C);
        send_payload(SHORT_BLOCK);
        frame_until_taken(SHORT_BLOCK + 5, alive);
    endtask

    // A full transfer, following the protocol with random trouble along the way.
    task automatic run_transfer(input int flen, input bit with_hold);
        bit alive;
        int left, n, tries, v;
        sessions++;
        if (with_hold) hold_req = 1'b1;
        open_and_header(alive);
        if (!alive) return;
        send_rx(CH_C);
        left = flen;
        while (left > 0) begin
            n = (left > LONG_BLOCK) ? LONG_BLOCK : left;
            send_payload(n);
            frame_until_taken((n < SHORT_BLOCK) ? SHORT_BLOCK + 5 : LONG_BLOCK + 5, alive);
            if (!alive) return;
            left -= n;
        end
        tries = 0;
        forever begin
            send_slots(1);
            answer(1'b0, v);
            if (v == 0) break;
            tries++;
            if (tries >= lim_attempt) return;
        end
        send_rx(CH_C);
        send_slots(SHORT_BLOCK + 5);
        if ($urandom_range(0, 1)) send(REQ_TIMEOUT, 8'h00, 8'h00);
        else send_rx(CH_ACK);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_FILE_LEN;
        i_cfg_wdata   = 24'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = REQ_START;
        items_sent    = 0;
        sessions      = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        lim_attempt   = ATTEMPT_RST;
        lim_start     = START_RST;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Out-of-place items from idle, then a start with a zero start limit that gives up on its second reply.
        set_all(24'd0, 10, 0, 3);
        send(REQ_PAYLOAD, 8'hFF, 8'h00);
        send(REQ_SLOT, 8'h00, 8'hFF);
        send(t_req'(3'd7), 8'hAA, 8'h55);
        send_rx(CH_ACK);
        send(REQ_START, 8'h00, 8'h00);
        send_rx(8'h00);
        send(REQ_TIMEOUT, 8'h00, 8'h00);
        send_rx(CH_NAK);

        // Start wait at the top limit: the counter saturates and fails one early.
        set_all(24'd0, 10, 127, 3);
        send(REQ_START, 8'h00, 8'h00);
        repeat (130) send(REQ_TIMEOUT, 8'h00, 8'h00);

        // Zero limits act as one: a single NAK fails the header.
        set_all(24'd0, 0, 100, 0);
        sessions++;
        send(REQ_START, 8'h00, 8'h00);
        send_rx(CH_C);
        send_payload(SHORT_BLOCK);
        send_slots(SHORT_BLOCK + 5);
        send_rx(CH_NAK);

        // A short transfer that opens with the receiver holding off while slots keep coming.
        set_all(24'd100, 15, 100, 3);
        run_transfer(100, 1'b1);

        // Free-form items, starts included, up to the item goal.
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 3) == 0) send_junk();
            else send(t_req'($urandom_range(0, 4)), $urandom_range(0, 255),
                      ($urandom_range(0, 1)) ? $urandom_range(0, 255) : CH_ACK);
        end

        settle();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d transfers, %0d input items and %0d result items in %0d cycles",
                 sessions, items_sent, results, cycles);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d field mismatches", fail_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ymsnd_pkg.sv
rtl/core/ymsnd_store.sv
rtl/core/ymsnd_ctrl.sv
rtl/core/ymsnd_emit.sv
rtl/core/ymodem_1k_sender_unit.sv
rtl/core/ymsnd_checker.sv
tb/sv/ymsnd_checker.sv
tb/sv/tb_top.sv
